[rtl/tac_pkg.sv]
// Shared types and default constants for the tamper alarm controller.
package tac_pkg;

  localparam int TimeWidthDefault      = 32;
  localparam int AlertHoldoffDefault   = 3000;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic [15:0] PulseDebounceReset = 16'd80;
  localparam logic [15:0] PulseWindowReset   = 16'd1000;
  localparam logic [7:0]  PulseThreshReset   = 8'd1;
  localparam logic [15:0] VibHoldReset       = 16'd3000;
  localparam logic [15:0] DoorSettleReset    = 16'd100;
  localparam logic [15:0] ClosedLingerReset  = 16'd2000;
  localparam logic [15:0] BlinkHalfReset     = 16'd350;
  localparam logic [15:0] ResetIgnoreReset   = 16'd5000;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_PULSE_DEBOUNCE = 3'd0,
    CFG_PULSE_WINDOW   = 3'd1,
    CFG_PULSE_THRESH   = 3'd2,
    CFG_VIB_HOLD       = 3'd3,
    CFG_DOOR_SETTLE    = 3'd4,
    CFG_CLOSED_LINGER  = 3'd5,
    CFG_BLINK_HALF     = 3'd6,
    CFG_RESET_IGNORE   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ALARM_SECURE    = 2'd0,
    ALARM_VIBRATION = 2'd1,
    ALARM_DOOR      = 2'd2,
    ALARM_EMERGENCY = 2'd3
  } alarm_e;

  typedef struct packed {
    logic   alert_pulse;
    logic   state_changed;
    logic   door_is_open;
    logic   vibration_active;
    logic   buzzer_on;
    alarm_e alarm_state;
  } result_t;

endpackage

[rtl/tamper_alarm_controller_top.sv]
// Tamper alarm controller: vibration and door supervision, alarm state and buzzer drive.
// Latency: a result beat appears in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle; the single result register is refilled in the
// same cycle it is drained, so the only stall comes from the output side.
// Reset: asynchronous, active low; all timers, flags and counts clear to zero, the alarm
// goes secure and the configuration registers return to their default values.
module tamper_alarm_controller_top import tac_pkg::*; #(
  parameter int TIME_WIDTH       = TimeWidthDefault,
  parameter int ALERT_HOLDOFF_MS = AlertHoldoffDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [0] vibration_raw, [1] door_raw, [2] remote_reset, [7:3] zero
  input  logic [7:0]               s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [1:0] alarm_state, [2] buzzer_on, [3] vibration_active, [4] door_is_open,
  // [5] state_changed, [6] alert_pulse, [7] zero
  output logic [7:0]               m_axis_tdata,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  localparam int TW = TIME_WIDTH;
  localparam logic [TW-1:0] Holdoff = TW'(ALERT_HOLDOFF_MS);

  typedef logic [TW-1:0] time_t;

  function automatic time_t elapsed(time_t now, time_t mark);
    return now - mark;
  endfunction

  // Strictly later: nonzero difference below half of the time range.
  function automatic logic later(time_t a, time_t b);
    time_t d;
    d = a - b;
    return (d != '0) && !d[TW-1];
  endfunction

  // Configuration registers.
  logic [15:0] debounce_q, window_q, hold_q, settle_q, linger_q, blink_q, ignore_q;
  logic [7:0]  thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= PulseDebounceReset;
      window_q   <= PulseWindowReset;
      thresh_q   <= PulseThreshReset;
      hold_q     <= VibHoldReset;
      settle_q   <= DoorSettleReset;
      linger_q   <= ClosedLingerReset;
      blink_q    <= BlinkHalfReset;
      ignore_q   <= ResetIgnoreReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PULSE_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_PULSE_WINDOW:   window_q   <= cfg_data_i;
        CFG_PULSE_THRESH:   thresh_q   <= cfg_data_i[7:0];
        CFG_VIB_HOLD:       hold_q     <= cfg_data_i;
        CFG_DOOR_SETTLE:    settle_q   <= cfg_data_i;
        CFG_CLOSED_LINGER:  linger_q   <= cfg_data_i;
        CFG_BLINK_HALF:     blink_q    <= cfg_data_i;
        CFG_RESET_IGNORE:   ignore_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Block state.
  time_t  tick_q, last_pulse_q, win_start_q, vib_until_q, door_chg_q, door_closed_q;
  time_t  toggle_q, ign_until_q, last_alert_q;
  logic [7:0] pulse_cnt_q;
  logic   vib_flag_q, door_open_q, prev_door_q, just_closed_q, blink_lvl_q, buzzer_q;
  logic   ign_q;
  alarm_e alarm_q;

  time_t  tick_d, last_pulse_d, win_start_d, vib_until_d, door_chg_d, door_closed_d;
  time_t  toggle_d, ign_until_d, last_alert_d;
  logic [7:0] pulse_cnt_d;
  logic   vib_flag_d, door_open_d, prev_door_d, just_closed_d, blink_lvl_d, buzzer_d;
  logic   ign_d;
  alarm_e alarm_d;
  result_t res_d;

  logic s_fire;
  logic out_valid_q;
  result_t out_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

  always_comb begin
    logic   vib, door, rreq;
    time_t  t;
    alarm_e nxt;
    logic   alert;

    vib  = s_axis_tdata[0];
    door = s_axis_tdata[1];
    rreq = s_axis_tdata[2];

    tick_d        = tick_q;
    last_pulse_d  = last_pulse_q;
    win_start_d   = win_start_q;
    vib_until_d   = vib_until_q;
    door_chg_d    = door_chg_q;
    door_closed_d = door_closed_q;
    toggle_d      = toggle_q;
    ign_until_d   = ign_until_q;
    last_alert_d  = last_alert_q;
    pulse_cnt_d   = pulse_cnt_q;
    vib_flag_d    = vib_flag_q;
    door_open_d   = door_open_q;
    prev_door_d   = prev_door_q;
    just_closed_d = just_closed_q;
    blink_lvl_d   = blink_lvl_q;
    buzzer_d      = buzzer_q;
    ign_d         = ign_q;
    alarm_d       = alarm_q;
    alert         = 1'b0;
    nxt           = ALARM_SECURE;

    t      = tick_q + time_t'(1);
    tick_d = t;

    if (rreq) begin
      vib_flag_d    = 1'b0;
      door_open_d   = 1'b0;
      just_closed_d = 1'b0;
      pulse_cnt_d   = '0;
      vib_until_d   = '0;
      alarm_d       = ALARM_SECURE;
      ign_d         = 1'b1;
      ign_until_d   = t + time_t'(ignore_q);
      buzzer_d      = 1'b0;
    end

    if (ign_d && later(t, ign_until_d)) ign_d = 1'b0;

    if (!ign_d) begin
      if (vib && (elapsed(t, last_pulse_d) > time_t'(debounce_q))) begin
        last_pulse_d = t;
        if (elapsed(t, win_start_d) > time_t'(window_q)) begin
          pulse_cnt_d = '0;
          win_start_d = t;
        end
        if (pulse_cnt_d != 8'hFF) pulse_cnt_d = pulse_cnt_d + 8'd1;
        if (pulse_cnt_d >= thresh_q) begin
          vib_flag_d  = 1'b1;
          vib_until_d = t + time_t'(hold_q);
          pulse_cnt_d = '0;
          win_start_d = t;
        end
      end
      if (vib_flag_d && later(t, vib_until_d)) vib_flag_d = 1'b0;

      if (door != prev_door_d) begin
        door_chg_d  = t;
        prev_door_d = door;
      end
      if (elapsed(t, door_chg_d) >= time_t'(settle_q)) begin
        if (door && !door_open_d) begin
          door_open_d   = 1'b1;
          just_closed_d = 1'b0;
        end else if (!door && door_open_d) begin
          door_open_d   = 1'b0;
          just_closed_d = 1'b1;
          door_closed_d = t;
        end
      end
    end

    if (vib_flag_d && door_open_d) nxt = ALARM_EMERGENCY;
    else if (door_open_d)          nxt = ALARM_DOOR;
    else if (vib_flag_d)           nxt = ALARM_VIBRATION;
    else                           nxt = ALARM_SECURE;

    if (nxt != alarm_d) begin
      alarm_d = nxt;
      if ((nxt != ALARM_SECURE) && (elapsed(t, last_alert_d) >= Holdoff)) begin
        alert        = 1'b1;
        last_alert_d = t;
      end
    end

    if (just_closed_d && !door_open_d && (elapsed(t, door_closed_d) >= time_t'(linger_q)))
      just_closed_d = 1'b0;

    // A secure alarm still blinks while the door-closed linger runs.
    if ((alarm_d == ALARM_SECURE) && !just_closed_d) begin
      if (!vib_flag_d) buzzer_d = 1'b0;
    end else if (alarm_d == ALARM_EMERGENCY) begin
      buzzer_d = 1'b1;
    end else if (alarm_d == ALARM_VIBRATION) begin
      buzzer_d = later(vib_until_d, t);
    end else begin
      if (elapsed(t, toggle_d) >= time_t'(blink_q)) begin
        toggle_d    = t;
        blink_lvl_d = !blink_lvl_d;
        buzzer_d    = blink_lvl_d;
      end
    end

    res_d.alarm_state      = alarm_d;
    res_d.buzzer_on        = buzzer_d;
    res_d.vibration_active = vib_flag_d;
    res_d.door_is_open     = door_open_d;
    res_d.state_changed    = (alarm_d != alarm_q);
    res_d.alert_pulse      = alert;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q        <= '0;
      last_pulse_q  <= '0;
      win_start_q   <= '0;
      vib_until_q   <= '0;
      door_chg_q    <= '0;
      door_closed_q <= '0;
      toggle_q      <= '0;
      ign_until_q   <= '0;
      last_alert_q  <= '0;
      pulse_cnt_q   <= '0;
      vib_flag_q    <= 1'b0;
      door_open_q   <= 1'b0;
      prev_door_q   <= 1'b0;
      just_closed_q <= 1'b0;
      blink_lvl_q   <= 1'b0;
      buzzer_q      <= 1'b0;
      ign_q         <= 1'b0;
      alarm_q       <= ALARM_SECURE;
    end else if (s_fire) begin
      tick_q        <= tick_d;
      last_pulse_q  <= last_pulse_d;
      win_start_q   <= win_start_d;
      vib_until_q   <= vib_until_d;
      door_chg_q    <= door_chg_d;
      door_closed_q <= door_closed_d;
      toggle_q      <= toggle_d;
      ign_until_q   <= ign_until_d;
      last_alert_q  <= last_alert_d;
      pulse_cnt_q   <= pulse_cnt_d;
      vib_flag_q    <= vib_flag_d;
      door_open_q   <= door_open_d;
      prev_door_q   <= prev_door_d;
      just_closed_q <= just_closed_d;
      blink_lvl_q   <= blink_lvl_d;
      buzzer_q      <= buzzer_d;
      ign_q         <= ign_d;
      alarm_q       <= alarm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) out_q <= res_d;
  end

  // An alert is only raised on a change into a non-secure state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.alert_pulse) |->
      (out_q.state_changed && (out_q.alarm_state != ALARM_SECURE)))
    else $error("alert without a change into an alarm state");

  // The reported alarm is emergency exactly when both flags are set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.alarm_state == ALARM_EMERGENCY) ==
                     (out_q.vibration_active && out_q.door_is_open)))
    else $error("alarm state disagrees with the flags");

  // Emergency always drives the buzzer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.alarm_state == ALARM_EMERGENCY)) |-> out_q.buzzer_on)
    else $error("buzzer off in emergency");

  // A remote reset beat leaves the alarm secure with no alert.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tdata[2]) |=>
      (out_valid_q && !out_q.alert_pulse && (out_q.alarm_state == ALARM_SECURE)))
    else $error("remote reset did not clear the alarm");

  // A result held by the output side is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule

[bench/testbench.sv]
// Self-checking bench for the tamper alarm controller: tick streams against a cycle-free predictor.
module testbench;
  import tac_pkg::*;

  typedef logic [15:0] cfg_set_t [8];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [0] vibration_raw, [1] door_raw, [2] remote_reset, [7:3] zero
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [1:0] alarm_state, [2] buzzer_on, [3] vibration_active, [4] door_is_open,
  // [5] state_changed, [6] alert_pulse, [7] zero
  logic [7:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  tamper_alarm_controller_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted controller state, mirroring the block from reset onward.
  logic [15:0] cfg_mirror [8] = '{PulseDebounceReset, PulseWindowReset, {8'd0, PulseThreshReset},
                                  VibHoldReset, DoorSettleReset, ClosedLingerReset,
                                  BlinkHalfReset, ResetIgnoreReset};
  logic [31:0] now_t = '0, last_pulse_t = '0, win_start_t = '0, vib_until_t = '0;
  logic [31:0] door_chg_t = '0, door_closed_t = '0, toggle_t = '0, ignore_until_t = '0;
  logic [31:0] last_alert_t = '0;
  logic [7:0]  pulse_cnt = '0;
  alarm_e      alarm_now = ALARM_SECURE;
  logic vib_flag = 1'b0, door_flag = 1'b0, door_prev = 1'b0, just_closed = 1'b0;
  logic blink_lvl = 1'b0, buzz_lvl = 1'b0, ignoring = 1'b0;

  result_t alarm_reports_due [$];
  int      fail_count = 0;
  bit      steady_mode = 1'b0;
  int      stall_left = 0;
  result_t got_report, want_report;

  function automatic logic [31:0] span(logic [31:0] now, logic [31:0] mark);
    return now - mark;
  endfunction

  // Wrap-safe "a is past b": nonzero distance within half the time range.
  function automatic logic is_after(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 0) && (d <= 32'h7FFF_FFFF);
  endfunction

  function automatic result_t predict_tick(logic vib, logic door, logic rr);
    result_t r;
    alarm_e  prev_alarm, nxt;
    logic    alert;
    prev_alarm = alarm_now;
    alert = 1'b0;
    now_t = now_t + 1;
    if (rr) begin
      vib_flag = 1'b0;
      door_flag = 1'b0;
      just_closed = 1'b0;
      pulse_cnt = '0;
      vib_until_t = '0;
      alarm_now = ALARM_SECURE;
      ignoring = 1'b1;
      ignore_until_t = now_t + cfg_mirror[CFG_RESET_IGNORE];
      buzz_lvl = 1'b0;
    end
    if (ignoring && is_after(now_t, ignore_until_t)) ignoring = 1'b0;
    if (!ignoring) begin
      if (vib && span(now_t, last_pulse_t) > cfg_mirror[CFG_PULSE_DEBOUNCE]) begin
        last_pulse_t = now_t;
        if (span(now_t, win_start_t) > cfg_mirror[CFG_PULSE_WINDOW]) begin
          pulse_cnt = '0;
          win_start_t = now_t;
        end
        if (pulse_cnt != 8'hFF) pulse_cnt = pulse_cnt + 8'd1;
        if (pulse_cnt >= cfg_mirror[CFG_PULSE_THRESH]) begin
          vib_flag = 1'b1;
          vib_until_t = now_t + cfg_mirror[CFG_VIB_HOLD];
          pulse_cnt = '0;
          win_start_t = now_t;
        end
      end
      if (vib_flag && is_after(now_t, vib_until_t)) vib_flag = 1'b0;
      if (door != door_prev) begin
        door_chg_t = now_t;
        door_prev = door;
      end
      if (span(now_t, door_chg_t) >= cfg_mirror[CFG_DOOR_SETTLE]) begin
        if (door && !door_flag) begin
          door_flag = 1'b1;
          just_closed = 1'b0;
        end else if (!door && door_flag) begin
          door_flag = 1'b0;
          just_closed = 1'b1;
          door_closed_t = now_t;
        end
      end
    end
    if (vib_flag && door_flag) nxt = ALARM_EMERGENCY;
    else if (door_flag) nxt = ALARM_DOOR;
    else if (vib_flag) nxt = ALARM_VIBRATION;
    else nxt = ALARM_SECURE;
    if (nxt != alarm_now) begin
      alarm_now = nxt;
      if (nxt != ALARM_SECURE && span(now_t, last_alert_t) >= 32'(AlertHoldoffDefault)) begin
        alert = 1'b1;
        last_alert_t = now_t;
      end
    end
    if (just_closed && !door_flag && span(now_t, door_closed_t) >= cfg_mirror[CFG_CLOSED_LINGER])
      just_closed = 1'b0;
    // A lingering just-closed door keeps the blink going even in the secure state.
    if (alarm_now == ALARM_SECURE && !just_closed) begin
      if (!vib_flag) buzz_lvl = 1'b0;
    end else if (alarm_now == ALARM_EMERGENCY) begin
      buzz_lvl = 1'b1;
    end else if (alarm_now == ALARM_VIBRATION) begin
      buzz_lvl = is_after(vib_until_t, now_t);
    end else if (span(now_t, toggle_t) >= cfg_mirror[CFG_BLINK_HALF]) begin
      toggle_t = now_t;
      blink_lvl = !blink_lvl;
      buzz_lvl = blink_lvl;
    end
    r.alarm_state = alarm_now;
    r.buzzer_on = buzz_lvl;
    r.vibration_active = vib_flag;
    r.door_is_open = door_flag;
    r.state_changed = (alarm_now != prev_alarm);
    r.alert_pulse = alert;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid stays high after acceptance; it is lowered only by a gap or a drain.
  task automatic send_tick(logic vib, logic door, logic rr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, rr, door, vib};
    do @(posedge clk_i); while (!s_axis_tready);
    alarm_reports_due.push_back(predict_tick(vib, door, rr));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (alarm_reports_due.size() != 0);
  endtask

  task automatic load_settings(input cfg_set_t vals);
    cfg_idx_e idx;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_mirror[i] = (idx == CFG_PULSE_THRESH) ? {8'd0, vals[i][7:0]} : vals[i];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Short timers and zero thresholds so each sensor path reacts within a few ticks,
  // including the every-pulse-confirms and toggle-every-tick corners.
  task automatic test_directed_corners();
    cfg_set_t s;
    logic [2:0] seq [22];
    s = '{16'd0, 16'd0, 16'd0, 16'd3, 16'd0, 16'd2, 16'd0, 16'd2};
    // Each entry is {remote_reset, door_raw, vibration_raw}.
    seq = '{3'b000, 3'b001, 3'b000, 3'b011, 3'b010, 3'b010, 3'b000, 3'b000,
            3'b000, 3'b010, 3'b010, 3'b010, 3'b011, 3'b111, 3'b011, 3'b011,
            3'b010, 3'b011, 3'b001, 3'b000, 3'b100, 3'b000};
    load_settings(s);
    foreach (seq[i]) send_tick(seq[i][0], seq[i][1], seq[i][2]);
  endtask

  // The first alert needs the holdoff to pass since time zero, so idle up to it first.
  task automatic test_alert_holdoff();
    cfg_set_t s;
    s = '{PulseDebounceReset, PulseWindowReset, {8'd0, PulseThreshReset}, VibHoldReset,
          DoorSettleReset, ClosedLingerReset, BlinkHalfReset, ResetIgnoreReset};
    load_settings(s);
    while (now_t < 32'(AlertHoldoffDefault)) send_tick(1'b0, 1'b0, 1'b0);
    repeat (160) send_tick(1'b0, 1'b1, 1'b0);
    repeat (160) send_tick(1'b0, 1'b0, 1'b0);
  endtask

  // Door levels are held in runs of random length, some too short to settle, with occasional
  // one-tick glitches; vibration pulses are random and remote resets are rare.
  task automatic test_random_traffic(input cfg_set_t s, input int n, input bit pause_midway);
    logic door_lvl, vib, rr;
    int run_left, cap;
    load_settings(s);
    door_lvl = door_prev;
    run_left = 0;
    cap = 3 * cfg_mirror[CFG_DOOR_SETTLE] + 4;
    if (cap > 200) cap = 200;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) steady_mode = ($urandom_range(0, 3) == 0);
      if (pause_midway && i == n / 2) wait_drained();
      if (run_left == 0) begin
        door_lvl = !door_lvl;
        run_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, cap);
      end
      run_left--;
      vib = ($urandom_range(0, 3) == 0);
      rr = ($urandom_range(0, 199) == 0);
      send_tick(vib, door_lvl, rr);
    end
    steady_mode = 1'b0;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!steady_mode && $urandom_range(0, 99) < 15) begin
      stall_left <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_report = result_t'(m_axis_tdata[6:0]);
      if (alarm_reports_due.size() == 0) begin
        $error("result beat with no tick outstanding: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want_report = alarm_reports_due.pop_front();
        check_field("alarm_state", int'(want_report.alarm_state),
                    int'(got_report.alarm_state));
        check_field("buzzer_on", int'(want_report.buzzer_on), int'(got_report.buzzer_on));
        check_field("vibration_active", int'(want_report.vibration_active),
                    int'(got_report.vibration_active));
        check_field("door_is_open", int'(want_report.door_is_open),
                    int'(got_report.door_is_open));
        check_field("state_changed", int'(want_report.state_changed),
                    int'(got_report.state_changed));
        check_field("alert_pulse", int'(want_report.alert_pulse),
                    int'(got_report.alert_pulse));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    cfg_set_t s;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();

    s = '{16'd2, 16'd20, 16'd3, 16'd30, 16'd3, 16'd20, 16'd4, 16'd25};
    test_random_traffic(s, 700, 1'b1);
    s = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    test_random_traffic(s, 350, 1'b0);
    s = '{16'hFFFF, 16'hFFFF, 16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    test_random_traffic(s, 150, 1'b0);
    s = '{16'($urandom_range(0, 8)), 16'($urandom_range(0, 60)), 16'($urandom_range(1, 5)),
          16'($urandom_range(0, 80)), 16'($urandom_range(0, 10)), 16'($urandom_range(0, 60)),
          16'($urandom_range(0, 10)), 16'($urandom_range(0, 50))};
    test_random_traffic(s, 750, 1'b0);

    test_alert_holdoff();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
